// ----- sv/cifr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the ignition frame relay controller.
// No dependencies.
package cifr_pkg;

    localparam int IdW   = 29;
    localparam int LenW  = 4;
    localparam int DataW = 64;
    localparam int TickW = 16;
    localparam int BlinkW = 8;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 29;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_PRE    = 2'd1,
        MODE_FORCED = 2'd2,
        MODE_ECHO   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_TICK_FAST = 2'd0,
        CMD_TICK_SLOW = 2'd1,
        CMD_CAR_FRAME = 2'd2,
        CMD_HU_FRAME  = 2'd3
    } cmd_t;

    localparam logic [CfgIdxW-1:0] CFG_WATCHED_ID     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SHUTDOWN_TICKS = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LOSS_TICKS     = 2'd2;

    localparam logic [IdW-1:0]   WATCHED_ID_RST     = 29'h130;
    localparam logic [TickW-1:0] SHUTDOWN_TICKS_RST = 16'd30000;
    localparam logic [TickW-1:0] LOSS_TICKS_RST     = 16'd200;

    localparam logic [BlinkW-1:0] BLINK_SAT = 8'd255;

    localparam logic SEND_PORT_HU  = 1'b0;
    localparam logic SEND_PORT_CAR = 1'b1;

    typedef struct packed {
        logic [IdW-1:0]   watched_id;
        logic [TickW-1:0] shutdown_ticks;
        logic [TickW-1:0] loss_ticks;
    } cfg_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [IdW-1:0]   frame_id;
        logic [LenW-1:0]  frame_len;
        logic [DataW-1:0] frame_data;
    } item_t;

    typedef struct packed {
        logic             send_valid;
        logic             send_port;
        logic [IdW-1:0]   send_id;
        logic [LenW-1:0]  send_len;
        logic [DataW-1:0] send_data;
        logic             led_level;
        mode_t            mode;
    } result_t;

    function automatic logic [BlinkW-1:0] blink_limit(mode_t m);
        logic [BlinkW-1:0] lim;
        unique case (m)
            MODE_IDLE:   lim = 8'd199;
            MODE_PRE:    lim = 8'd99;
            MODE_FORCED: lim = 8'd4;
            MODE_ECHO:   lim = 8'd19;
            default:     lim = 8'd199;
        endcase
        return lim;
    endfunction

endpackage

// ----- sv/cifr_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register bank: watched id and the two timer thresholds.
// Depends on cifr_pkg.
module cifr_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cifr_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [cifr_pkg::CfgDataW-1:0] cfg_data,
    output cifr_pkg::cfg_t                cfg
);

    cifr_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.watched_id     <= cifr_pkg::WATCHED_ID_RST;
            cfg_reg.shutdown_ticks <= cifr_pkg::SHUTDOWN_TICKS_RST;
            cfg_reg.loss_ticks     <= cifr_pkg::LOSS_TICKS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cifr_pkg::CFG_WATCHED_ID)
                cfg_reg.watched_id <= cfg_data;
            else if (cfg_index == cifr_pkg::CFG_SHUTDOWN_TICKS)
                cfg_reg.shutdown_ticks <= cfg_data[cifr_pkg::TickW-1:0];
            else if (cfg_index == cifr_pkg::CFG_LOSS_TICKS)
                cfg_reg.loss_ticks <= cfg_data[cifr_pkg::TickW-1:0];
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/cifr_core.sv -----
`timescale 1ns / 1ps
// Mode machine, timers, LED blink and stored ignition frame; computes the
// result for one item from the current state. Depends on cifr_pkg.
module cifr_core (
    input  logic             clk,
    input  logic             rst_n,
    input  cifr_pkg::cfg_t   cfg,
    input  cifr_pkg::item_t  item,
    input  logic             advance,
    output cifr_pkg::result_t result
);

    cifr_pkg::mode_t                  mode_reg, mode_next;
    logic [cifr_pkg::TickW-1:0]       ign_timer_reg, ign_timer_next;
    logic [cifr_pkg::TickW-1:0]       loss_timer_reg, loss_timer_next;
    logic [cifr_pkg::BlinkW-1:0]      blink_reg, blink_next;
    logic                             led_reg, led_next;
    logic                             have_stored_reg, have_stored_next;
    logic [cifr_pkg::IdW-1:0]         stored_id_reg;
    logic [cifr_pkg::LenW-1:0]        stored_len_reg;
    logic [cifr_pkg::DataW-1:0]       stored_data_reg;
    logic                             store_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= cifr_pkg::MODE_IDLE;
            ign_timer_reg   <= '0;
            loss_timer_reg  <= '0;
            blink_reg       <= '0;
            led_reg         <= 1'b0;
            have_stored_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            ign_timer_reg   <= ign_timer_next;
            loss_timer_reg  <= loss_timer_next;
            blink_reg       <= blink_next;
            led_reg         <= led_next;
            have_stored_reg <= have_stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && store_en)
        begin
            stored_id_reg   <= item.frame_id;
            stored_len_reg  <= item.frame_len;
            stored_data_reg <= item.frame_data;
        end
    end

    always_comb
    begin
        cifr_pkg::mode_t m1;
        logic [cifr_pkg::DataW-1:0] fdata;

        mode_next        = mode_reg;
        ign_timer_next   = ign_timer_reg;
        loss_timer_next  = loss_timer_reg;
        blink_next       = blink_reg;
        led_next         = led_reg;
        have_stored_next = have_stored_reg;
        store_en         = 1'b0;
        m1               = mode_reg;
        fdata            = item.frame_data;

        result.send_valid = 1'b0;
        result.send_port  = cifr_pkg::SEND_PORT_HU;
        result.send_id    = '0;
        result.send_len   = '0;
        result.send_data  = '0;

        unique case (item.cmd)
            cifr_pkg::CMD_TICK_FAST:
            begin
                if (blink_reg >= cifr_pkg::blink_limit(mode_reg))
                begin
                    blink_next = '0;
                    led_next   = ~led_reg;
                end
                else if (blink_reg < cifr_pkg::BLINK_SAT)
                begin
                    blink_next = blink_reg + 8'd1;
                end

                if (mode_reg != cifr_pkg::MODE_IDLE && ign_timer_reg < cfg.shutdown_ticks)
                    ign_timer_next = ign_timer_reg + 16'd1;
                if (ign_timer_next >= cfg.shutdown_ticks)
                begin
                    if (mode_reg == cifr_pkg::MODE_FORCED)
                        m1 = cifr_pkg::MODE_PRE;
                    else if (mode_reg == cifr_pkg::MODE_ECHO)
                        m1 = cifr_pkg::MODE_IDLE;
                end

                if ((m1 == cifr_pkg::MODE_FORCED || m1 == cifr_pkg::MODE_PRE)
                    && loss_timer_reg < cfg.loss_ticks)
                    loss_timer_next = loss_timer_reg + 16'd1;
                mode_next = m1;
                if (loss_timer_next >= cfg.loss_ticks)
                begin
                    if (m1 == cifr_pkg::MODE_FORCED)
                        mode_next = cifr_pkg::MODE_ECHO;
                    else if (m1 == cifr_pkg::MODE_PRE)
                        mode_next = cifr_pkg::MODE_IDLE;
                end
            end
            cifr_pkg::CMD_TICK_SLOW:
            begin
                if (mode_reg == cifr_pkg::MODE_ECHO && have_stored_reg)
                begin
                    result.send_valid = 1'b1;
                    result.send_port  = cifr_pkg::SEND_PORT_HU;
                    result.send_id    = stored_id_reg;
                    result.send_len   = stored_len_reg;
                    result.send_data  = stored_data_reg | 64'd1;
                end
            end
            cifr_pkg::CMD_CAR_FRAME:
            begin
                if (item.frame_id == cfg.watched_id)
                begin
                    store_en         = 1'b1;
                    have_stored_next = 1'b1;
                    loss_timer_next  = '0;
                    if (mode_reg == cifr_pkg::MODE_IDLE || mode_reg == cifr_pkg::MODE_ECHO
                        || item.frame_data[0])
                    begin
                        ign_timer_next = '0;
                        mode_next      = cifr_pkg::MODE_FORCED;
                    end
                    if (mode_next == cifr_pkg::MODE_FORCED)
                        fdata[0] = 1'b1;
                end
                result.send_valid = 1'b1;
                result.send_port  = cifr_pkg::SEND_PORT_HU;
                result.send_id    = item.frame_id;
                result.send_len   = item.frame_len;
                result.send_data  = fdata;
            end
            cifr_pkg::CMD_HU_FRAME:
            begin
                result.send_valid = 1'b1;
                result.send_port  = cifr_pkg::SEND_PORT_CAR;
                result.send_id    = item.frame_id;
                result.send_len   = item.frame_len;
                result.send_data  = item.frame_data;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        result.led_level = led_next;
        result.mode      = mode_next;
    end

endmodule

// ----- sv/can_ignition_frame_relay_fsm_top.sv -----
`timescale 1ns / 1ps
// Top level of the ignition frame relay controller.
// Depends on cifr_pkg, cifr_cfg and cifr_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: cmd
//   selects a 100 Hz tick, a 1 Hz tick, a car frame or a head-unit frame;
//   frame_id, frame_len and frame_data go with frames.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   item: send_valid with send_port/id/len/data, plus led_level and mode
//   as they stand after the item.
//   Timing: an accepted item is registered, processed against the current
//   state, and its result is registered in the result register; out_valid
//   is high from then on until the transfer.
//   Throughput: one item per cycle while the receiver does not stall, set
//   by the state update between the input register and the result register.
//   When the receiver stalls, the result register holds; the input register
//   then holds one more item and in_stall rises until the result drains.
//   Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle;
//   the block does not enforce it. Reset clears mode, timers, LED, the stored-frame
//   flag and both registers' valid flags; configuration returns to its defaults.
module can_ignition_frame_relay_fsm_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cifr_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [cifr_pkg::CfgDataW-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic [cifr_pkg::IdW-1:0]      frame_id,
    input  logic [cifr_pkg::LenW-1:0]     frame_len,
    input  logic [cifr_pkg::DataW-1:0]    frame_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          send_valid,
    output logic                          send_port,
    output logic [cifr_pkg::IdW-1:0]      send_id,
    output logic [cifr_pkg::LenW-1:0]     send_len,
    output logic [cifr_pkg::DataW-1:0]    send_data,
    output logic                          led_level,
    output logic [1:0]                    mode
);

    cifr_pkg::cfg_t    cfg;
    cifr_pkg::item_t   item_reg;
    cifr_pkg::result_t result;
    cifr_pkg::result_t res_reg;
    logic              item_vld_reg;
    logic              res_vld_reg;
    logic              advance;
    logic              in_take;

    cifr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cifr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .result  (result)
    );

    assign advance  = item_vld_reg && (!res_vld_reg || !out_stall);
    assign in_stall = item_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= in_take || (item_vld_reg && !advance);
            if (advance)
                res_vld_reg <= 1'b1;
            else if (!out_stall)
                res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd        <= cifr_pkg::cmd_t'(cmd);
            item_reg.frame_id   <= frame_id;
            item_reg.frame_len  <= frame_len;
            item_reg.frame_data <= frame_data;
        end
        if (advance)
            res_reg <= result;
    end

    assign out_valid  = res_vld_reg;
    assign send_valid = res_reg.send_valid;
    assign send_port  = res_reg.send_port;
    assign send_id    = res_reg.send_id;
    assign send_len   = res_reg.send_len;
    assign send_data  = res_reg.send_data;
    assign led_level  = res_reg.led_level;
    assign mode       = res_reg.mode;

endmodule
